// ----- rtl/shp_pkg.sv -----
// ----------------------------------------------------------------------------
// shp_pkg: shared types and constants for the stepper homing sequencer
// Step geometry, field widths, command and status codes, and the state record.
// ----------------------------------------------------------------------------
package shp_pkg;

  // Steps in one motor revolution. Must be a power of two so that the
  // position wraps by plain binary overflow.
  localparam int STEPS_PER_REV = 2048;
  localparam int REV_HALF      = STEPS_PER_REV / 2;

  // Fixed field widths of the channels.
  localparam int MODE_W   = 2;
  localparam int TGT_W    = 11;
  localparam int STEP_W   = 2;
  localparam int STATUS_W = 3;
  localparam int OPOS_W   = 11;
  localparam int ADJ_W    = 11;

  // Internal widths follow from the revolution size.
  localparam int POS_W  = $clog2(STEPS_PER_REV);
  localparam int CNT_W  = $clog2(2 * STEPS_PER_REV) + 1;
  localparam int SPAN_W = CNT_W - 1;
  localparam int REM_W  = CNT_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 2'd0,
    MODE_HOME = 2'd1,
    MODE_MOVE = 2'd2
  } mode_t;

  typedef enum logic [STEP_W-1:0] {
    STEP_NONE = 2'd0,
    STEP_FWD  = 2'd1,
    STEP_BWD  = 2'd2
  } step_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE   = 3'd0,
    ST_BUSY   = 3'd1,
    ST_DONE   = 3'd2,
    ST_FAIL   = 3'd3,
    ST_UNCAL  = 3'd4,
    ST_REJECT = 3'd5
  } status_t;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_LEAVE   = 11'b000_0000_0010,
    PH_SEEK_F  = 11'b000_0000_0100,
    PH_COUNT_F = 11'b000_0000_1000,
    PH_SEEK_B  = 11'b000_0001_0000,
    PH_COUNT_B = 11'b000_0010_0000,
    PH_CENTER  = 11'b000_0100_0000,
    PH_ADJ_F   = 11'b000_1000_0000,
    PH_ADJ_B   = 11'b001_0000_0000,
    PH_MOVE_F  = 11'b010_0000_0000,
    PH_MOVE_B  = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   step_counter;
    logic [SPAN_W-1:0]  first_span;
    logic [REM_W-1:0]   remaining_steps;
    logic [POS_W-1:0]   current_position;
    logic               homed;
  } seq_state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              sensor_active;
    logic [TGT_W-1:0]  target_position;
  } item_t;

  typedef struct packed {
    step_t   step_command;
    status_t status;
  } outcome_t;

endpackage

// ----- rtl/shp_item_if.sv -----
// ----------------------------------------------------------------------------
// shp_item_if: input channel of the stepper homing sequencer
// Valid/ready handshake carrying one tick or command beat.
// ----------------------------------------------------------------------------
interface shp_item_if;
  logic                        valid;
  logic                        ready;
  logic [shp_pkg::MODE_W-1:0]  mode;
  logic                        sensor_active;
  logic [shp_pkg::TGT_W-1:0]   target_position;

  modport source (output valid, output mode, output sensor_active,
                  output target_position, input ready);
  modport sink (input valid, input mode, input sensor_active,
                input target_position, output ready);
endinterface

// ----- rtl/shp_result_if.sv -----
// ----------------------------------------------------------------------------
// shp_result_if: result channel of the stepper homing sequencer
// Valid/ready handshake carrying one step command and status beat.
// ----------------------------------------------------------------------------
interface shp_result_if;
  logic                          valid;
  logic                          ready;
  logic [shp_pkg::STEP_W-1:0]    step_command;
  logic [shp_pkg::STATUS_W-1:0]  status;
  logic                          calibrated;
  logic [shp_pkg::OPOS_W-1:0]    position;

  modport source (output valid, output step_command, output status,
                  output calibrated, output position, input ready);
  modport sink (input valid, input step_command, input status,
                input calibrated, input position, output ready);
endinterface

// ----- rtl/shp_seq_core.sv -----
// ----------------------------------------------------------------------------
// shp_seq_core: single-pass next-state logic of the homing sequencer
// Takes the stored sequencer state and one beat, gives the next state and result.
// ----------------------------------------------------------------------------
module shp_seq_core (
  input  shp_pkg::seq_state_t              st,
  input  shp_pkg::item_t                   item,
  input  logic signed [shp_pkg::ADJ_W-1:0] adj,
  output shp_pkg::seq_state_t              st_next,
  output shp_pkg::outcome_t                outcome
);

  localparam int A_W = shp_pkg::REM_W + 1;
  localparam int SUM_W = shp_pkg::CNT_W + 1;

  // Resolves counted phases whose remaining count has reached zero.
  function automatic void settle(input shp_pkg::seq_state_t s_in,
                                 input logic signed [shp_pkg::ADJ_W-1:0] a_in,
                                 output shp_pkg::seq_state_t s_out,
                                 output logic done);
    logic signed [A_W-1:0] a;
    logic [A_W-1:0]        a_mag;
    s_out = s_in;
    done  = 1'b0;
    a     = A_W'(0) - A_W'(s_in.first_span) - A_W'(a_in);
    a_mag = a[A_W-1] ? A_W'(-a) : A_W'(a);
    if (s_out.phase == shp_pkg::PH_CENTER && s_out.remaining_steps == '0) begin
      s_out.phase = a[A_W-1] ? shp_pkg::PH_ADJ_B : shp_pkg::PH_ADJ_F;
      s_out.remaining_steps = shp_pkg::REM_W'(a_mag);
    end
    if ((s_out.phase == shp_pkg::PH_ADJ_F || s_out.phase == shp_pkg::PH_ADJ_B) &&
        s_out.remaining_steps == '0) begin
      s_out.current_position = '0;
      s_out.homed = 1'b1;
      s_out.phase = shp_pkg::PH_IDLE;
      done = 1'b1;
    end else if ((s_out.phase == shp_pkg::PH_MOVE_F ||
                  s_out.phase == shp_pkg::PH_MOVE_B) &&
                 s_out.remaining_steps == '0) begin
      s_out.phase = shp_pkg::PH_IDLE;
      done = 1'b1;
    end
  endfunction

  shp_pkg::seq_state_t          w;
  shp_pkg::seq_state_t          w_s1;
  shp_pkg::seq_state_t          w_s2;
  logic                         done1;
  logic                         done2;
  logic [shp_pkg::CNT_W-1:0]    cnt_inc;
  logic [SUM_W-1:0]             span_sum;
  logic [shp_pkg::POS_W-1:0]    tgt;
  logic [shp_pkg::POS_W-1:0]    diff;
  logic signed [shp_pkg::POS_W:0] raw;
  logic                         fwd;

  always_comb begin
    w        = st;
    w_s1     = st;
    w_s2     = st;
    done1    = 1'b0;
    done2    = 1'b0;
    cnt_inc  = st.step_counter + shp_pkg::CNT_W'(1);
    span_sum = '0;
    tgt      = shp_pkg::POS_W'(item.target_position);
    diff     = tgt - st.current_position;
    raw      = $signed({1'b0, tgt}) - $signed({1'b0, st.current_position});
    fwd      = (raw > 0 && raw <= shp_pkg::REV_HALF) || (raw < -shp_pkg::REV_HALF);
    outcome.step_command = shp_pkg::STEP_NONE;
    outcome.status       = shp_pkg::ST_BUSY;

    unique case (item.mode)
      shp_pkg::MODE_TICK: begin
        // Phase changes that take no step are resolved first, in order.
        if (w.phase == shp_pkg::PH_LEAVE &&
            !(item.sensor_active &&
              w.step_counter < shp_pkg::CNT_W'(shp_pkg::STEPS_PER_REV))) begin
          w.phase = shp_pkg::PH_SEEK_F;
          w.step_counter = '0;
        end
        if (item.sensor_active && w.phase == shp_pkg::PH_SEEK_F) begin
          w.phase = shp_pkg::PH_COUNT_F;
          w.step_counter = '0;
        end else if (item.sensor_active && w.phase == shp_pkg::PH_SEEK_B) begin
          w.phase = shp_pkg::PH_COUNT_B;
          w.step_counter = '0;
        end
        if (!item.sensor_active && w.phase == shp_pkg::PH_COUNT_F) begin
          w.first_span = shp_pkg::SPAN_W'(w.step_counter);
          w.phase = shp_pkg::PH_SEEK_B;
          w.step_counter = '0;
        end else if (!item.sensor_active && w.phase == shp_pkg::PH_COUNT_B) begin
          span_sum = SUM_W'(w.first_span) + SUM_W'(w.step_counter);
          w.remaining_steps = shp_pkg::REM_W'(span_sum >> 1);
          w.first_span = shp_pkg::SPAN_W'(span_sum >> 2);
          w.phase = shp_pkg::PH_CENTER;
        end
        cnt_inc = w.step_counter + shp_pkg::CNT_W'(1);

        unique case (w.phase)
          shp_pkg::PH_LEAVE: begin
            outcome.step_command = shp_pkg::STEP_FWD;
            w.step_counter = cnt_inc;
          end
          shp_pkg::PH_SEEK_F, shp_pkg::PH_SEEK_B: begin
            outcome.step_command = (w.phase == shp_pkg::PH_SEEK_F) ?
                                   shp_pkg::STEP_FWD : shp_pkg::STEP_BWD;
            w.step_counter = cnt_inc;
            if (cnt_inc >= shp_pkg::CNT_W'(shp_pkg::STEPS_PER_REV)) begin
              w.phase = shp_pkg::PH_IDLE;
              outcome.status = shp_pkg::ST_FAIL;
            end
          end
          shp_pkg::PH_COUNT_F, shp_pkg::PH_COUNT_B: begin
            outcome.step_command = (w.phase == shp_pkg::PH_COUNT_F) ?
                                   shp_pkg::STEP_FWD : shp_pkg::STEP_BWD;
            w.step_counter = cnt_inc;
            if (cnt_inc >= shp_pkg::CNT_W'(2 * shp_pkg::STEPS_PER_REV)) begin
              w.phase = shp_pkg::PH_IDLE;
              outcome.status = shp_pkg::ST_FAIL;
            end
          end
          shp_pkg::PH_CENTER, shp_pkg::PH_ADJ_F, shp_pkg::PH_ADJ_B,
          shp_pkg::PH_MOVE_F, shp_pkg::PH_MOVE_B: begin
            settle(w, adj, w_s1, done1);
            w_s2 = w_s1;
            if (w_s1.phase != shp_pkg::PH_IDLE) begin
              if (w_s1.phase == shp_pkg::PH_MOVE_B || w_s1.phase == shp_pkg::PH_ADJ_B) begin
                outcome.step_command = shp_pkg::STEP_BWD;
              end else begin
                outcome.step_command = shp_pkg::STEP_FWD;
              end
              if (w_s1.phase == shp_pkg::PH_MOVE_F) begin
                w_s1.current_position = w_s1.current_position + shp_pkg::POS_W'(1);
              end else if (w_s1.phase == shp_pkg::PH_MOVE_B) begin
                w_s1.current_position = w_s1.current_position - shp_pkg::POS_W'(1);
              end
              w_s1.remaining_steps = w_s1.remaining_steps - shp_pkg::REM_W'(1);
              settle(w_s1, adj, w_s2, done2);
            end
            w = w_s2;
            if (done1 || done2) begin
              outcome.status = shp_pkg::ST_DONE;
            end
          end
          shp_pkg::PH_IDLE: begin
            outcome.status = shp_pkg::ST_IDLE;
          end
          default: begin
            w.phase = shp_pkg::PH_IDLE;
            outcome.status = shp_pkg::ST_IDLE;
          end
        endcase
      end

      shp_pkg::MODE_HOME: begin
        if (st.phase != shp_pkg::PH_IDLE) begin
          outcome.status = shp_pkg::ST_REJECT;
        end else begin
          w.current_position = '0;
          w.homed = 1'b0;
          w.step_counter = '0;
          w.first_span = '0;
          w.remaining_steps = '0;
          w.phase = shp_pkg::PH_LEAVE;
        end
      end

      shp_pkg::MODE_MOVE: begin
        if (st.phase != shp_pkg::PH_IDLE) begin
          outcome.status = shp_pkg::ST_REJECT;
        end else if (!st.homed) begin
          outcome.status = shp_pkg::ST_UNCAL;
        end else if (diff == '0) begin
          outcome.status = shp_pkg::ST_DONE;
        end else begin
          w.phase = fwd ? shp_pkg::PH_MOVE_F : shp_pkg::PH_MOVE_B;
          w.remaining_steps = fwd ? shp_pkg::REM_W'(diff) :
                                    shp_pkg::REM_W'(shp_pkg::POS_W'(-diff));
        end
      end

      default: begin
        outcome.status = (st.phase == shp_pkg::PH_IDLE) ? shp_pkg::ST_IDLE :
                                                          shp_pkg::ST_BUSY;
      end
    endcase
    st_next = w;
  end

endmodule

// ----- rtl/stepper_homing_and_positioning.sv -----
// ----------------------------------------------------------------------------
// stepper_homing_and_positioning: homing and positioning sequencer top level
// Each accepted beat is one sensor tick or one command; each beat returns
// exactly one result beat with a step command, status, calibration flag and
// position. The block takes one beat per clock cycle while the downstream
// takes every result: a beat is captured in an input register, its whole
// step decision is made in one pass of the sequencer logic, and the answer
// is written into the output register once that register is free or is being
// emptied. Throughput is set by the output register alone; the input side
// only stalls when a result is waiting and the downstream is not taking it.
// The centering adjustment register may be written only while no beat is
// in flight.
// ----------------------------------------------------------------------------
module stepper_homing_and_positioning (
  input  logic                        clk,
  input  logic                        rst,
  shp_item_if.sink                    item,
  shp_result_if.source                result,
  input  logic                        cfg_write_en,
  input  logic [shp_pkg::ADJ_W-1:0]   cfg_write_data
);

  // Signed count of extra backward steps after centering on the sensor.
  logic signed [shp_pkg::ADJ_W-1:0] adj;

  // Input register holding one accepted beat.
  logic            hold_valid;
  shp_pkg::item_t  hold;

  // Sequencer state and its next value from the step logic.
  shp_pkg::seq_state_t st;
  shp_pkg::seq_state_t st_next;
  shp_pkg::outcome_t   outcome;

  // Output register.
  logic                         res_valid;
  shp_pkg::outcome_t            res;
  logic                         res_calibrated;
  logic [shp_pkg::OPOS_W-1:0]   res_position;

  logic advance;

  // The held beat moves forward whenever the output register is free or is
  // being emptied in this cycle. The input side takes a new beat in the same
  // cycle, so back-to-back beats flow at one per clock while results are taken.
  assign advance    = hold_valid && (!res_valid || result.ready);
  assign item.ready = !hold_valid || advance;

  shp_seq_core u_core (
    .st      (st),
    .item    (hold),
    .adj     (adj),
    .st_next (st_next),
    .outcome (outcome)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      adj <= '0;
    end else if (cfg_write_en) begin
      adj <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold.mode            <= item.mode;
      hold.sensor_active   <= item.sensor_active;
      hold.target_position <= item.target_position;
    end
  end

  // The sequencer state only changes when a beat is actually processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase            <= shp_pkg::PH_IDLE;
      st.step_counter     <= '0;
      st.first_span       <= '0;
      st.remaining_steps  <= '0;
      st.current_position <= '0;
      st.homed            <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res            <= outcome;
      res_calibrated <= st_next.homed;
      res_position   <= shp_pkg::OPOS_W'(st_next.current_position);
    end
  end

  assign result.valid        = res_valid;
  assign result.step_command = res.step_command;
  assign result.status       = res.status;
  assign result.calibrated   = res_calibrated;
  assign result.position     = res_position;

`ifndef SYNTH
  // Until a homing run completes the position is held at zero.
  a_uncal_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !st.homed |-> st.current_position == '0)
    else $error("position moved while not calibrated");

  // Every run leaves the remaining count drained when it returns to idle.
  a_idle_rem_zero: assert property (@(posedge clk) disable iff (rst)
    st.phase == shp_pkg::PH_IDLE |-> st.remaining_steps == '0)
    else $error("idle with steps still pending");

  // A move can only be under way on a calibrated motor.
  a_move_homed: assert property (@(posedge clk) disable iff (rst)
    (st.phase == shp_pkg::PH_MOVE_F || st.phase == shp_pkg::PH_MOVE_B) |-> st.homed)
    else $error("move running without calibration");

  // A step is only issued together with busy, done or failed status.
  a_step_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.step_command != shp_pkg::STEP_NONE) |->
    (res.status == shp_pkg::ST_BUSY || res.status == shp_pkg::ST_DONE ||
     res.status == shp_pkg::ST_FAIL))
    else $error("step issued with a command-only status");
`endif

endmodule
